FILE: src/csp_pkg.sv
`default_nettype none

package csp_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int TASK_BITS      = 5;
   localparam int PORT_PRIO_BITS = 8;
   localparam int TICKS_BITS     = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [TICKS_BITS-1:0] TIMEOUT_FOREVER = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELOAD  = 2'd1;

   localparam logic [COUNT_BITS-1:0] CEILING_RESET = 16'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET   = 16'd0;

   typedef enum logic [1:0] {
      FUNC_WAIT    = 2'd0,
      FUNC_SIGNAL  = 2'd1,
      FUNC_TIMEOUT = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      STATUS_ACQUIRED = 3'd0,
      STATUS_REFUSED  = 3'd1,
      STATUS_QUEUED   = 3'd2,
      STATUS_WOKE     = 3'd3,
      STATUS_COUNTED  = 3'd4,
      STATUS_REMOVED  = 3'd5,
      STATUS_IGNORED  = 3'd6,
      STATUS_FULL     = 3'd7
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

FILE: src/csp_ctrl.sv
`default_nettype none

module csp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   output csp_pkg::ctrl_cmd_type cmd
);

   csp_pkg::state_type state_ff;
   csp_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = csp_pkg::ST_EXEC;
            end
         end
         csp_pkg::ST_EXEC: begin
            state_in = csp_pkg::ST_IDLE;
         end
         default: begin
            state_in = csp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      case (state_ff)
         csp_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         csp_pkg::ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/csp_datapath.sv
`default_nettype none

module csp_datapath #(
   parameter int MAX_WAITERS   = 16,
   parameter int NUM_TASKS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  csp_pkg::ctrl_cmd_type                      cmd,
   input  wire  [1:0]                                 req_func,
   input  wire  [csp_pkg::TASK_BITS-1:0]              req_task_id,
   input  wire  [csp_pkg::PORT_PRIO_BITS-1:0]         req_task_priority,
   input  wire  [csp_pkg::TICKS_BITS-1:0]             req_timeout_ticks,
   input  wire                                        csr_valid,
   input  wire  [csp_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  wire  [csp_pkg::COUNT_BITS-1:0]             csr_wdata,
   output logic                                       rsp_valid,
   output logic [2:0]                                 rsp_status,
   output logic [csp_pkg::TASK_BITS-1:0]              rsp_woken_task,
   output logic                                       rsp_start_timer,
   output logic [csp_pkg::COUNT_BITS-1:0]             rsp_count_now
);

   localparam int TOTAL_BITS = $clog2(MAX_WAITERS + 1);
   localparam int TB         = csp_pkg::TASK_BITS;
   localparam int CB         = csp_pkg::COUNT_BITS;

   // sorted waiter cells, head at index zero, highest priority first
   logic [TB-1:0]            task_ff [MAX_WAITERS];
   logic [TB-1:0]            task_in [MAX_WAITERS];
   logic [PRIORITY_BITS-1:0] prio_ff [MAX_WAITERS];
   logic [PRIORITY_BITS-1:0] prio_in [MAX_WAITERS];
   logic [TOTAL_BITS-1:0]    total_ff;
   logic [TOTAL_BITS-1:0]    total_in;

   logic [CB-1:0] ceiling_ff;
   logic [CB-1:0] count_ff;
   logic [CB-1:0] count_in;

   // latched request item
   csp_pkg::func_type        func_ff;
   logic [TB-1:0]            id_ff;
   logic [PRIORITY_BITS-1:0] req_prio_ff;
   logic                     ticks_zero_ff;
   logic                     ticks_forever_ff;

   logic                     rsp_valid_ff;
   csp_pkg::status_type      status_ff;
   csp_pkg::status_type      status_in;
   logic [TB-1:0]            woken_ff;
   logic [TB-1:0]            woken_in;
   logic                     timer_ff;
   logic                     timer_in;

   logic [MAX_WAITERS-1:0] occ;
   logic [MAX_WAITERS-1:0] ge;
   logic [MAX_WAITERS-1:0] match;
   logic [MAX_WAITERS-1:0] ins_hot;
   logic [MAX_WAITERS-1:0] rm_mask;
   logic                   do_insert;
   logic                   do_remove;
   logic                   id_out_range;
   logic                   list_full;

   always_comb begin
      for (int k = 0; k < MAX_WAITERS; k++) begin
         occ[k]   = TOTAL_BITS'(k) < total_ff;
         ge[k]    = occ[k] && (prio_ff[k] >= req_prio_ff);
         match[k] = occ[k] && (task_ff[k] == id_ff);
      end
      // ge is a prefix since cells are sorted; insert at its first clear bit
      ins_hot = ~ge & {ge[MAX_WAITERS-2:0], 1'b1};
   end

   assign id_out_range = 32'(id_ff) >= NUM_TASKS;
   assign list_full    = total_ff == TOTAL_BITS'(MAX_WAITERS);

   always_comb begin
      status_in = csp_pkg::STATUS_IGNORED;
      woken_in  = '0;
      timer_in  = 1'b0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      rm_mask   = '1;
      count_in  = count_ff;
      case (func_ff)
         csp_pkg::FUNC_WAIT: begin
            if (count_ff != '0) begin
               status_in = csp_pkg::STATUS_ACQUIRED;
               count_in  = count_ff - CB'(1);
            end else if (ticks_zero_ff || id_out_range) begin
               status_in = csp_pkg::STATUS_REFUSED;
            end else if (list_full) begin
               status_in = csp_pkg::STATUS_FULL;
            end else begin
               status_in = csp_pkg::STATUS_QUEUED;
               do_insert = 1'b1;
               timer_in  = ~ticks_forever_ff;
            end
         end
         csp_pkg::FUNC_SIGNAL: begin
            if (total_ff != '0) begin
               status_in = csp_pkg::STATUS_WOKE;
               woken_in  = task_ff[0];
               do_remove = 1'b1;
            end else begin
               status_in = csp_pkg::STATUS_COUNTED;
               if (count_ff < ceiling_ff) begin
                  count_in = count_ff + CB'(1);
               end
            end
         end
         csp_pkg::FUNC_TIMEOUT: begin
            if (|match) begin
               status_in = csp_pkg::STATUS_REMOVED;
               do_remove = 1'b1;
               // every cell from the first match upward
               rm_mask   = match | (~match + MAX_WAITERS'(1));
            end
         end
         default: begin
            status_in = csp_pkg::STATUS_IGNORED;
         end
      endcase
      if (!cmd.exec) begin
         count_in = count_ff;
      end
      if (csr_valid && csr_index == csp_pkg::CSR_RELOAD) begin
         count_in = csr_wdata;
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_WAITERS; k++) begin
         task_in[k] = task_ff[k];
         prio_in[k] = prio_ff[k];
         if (do_insert && !ge[k]) begin
            if (ins_hot[k]) begin
               task_in[k] = id_ff;
               prio_in[k] = req_prio_ff;
            end else if (k > 0) begin
               task_in[k] = task_ff[k-1];
               prio_in[k] = prio_ff[k-1];
            end
         end else if (do_remove && rm_mask[k] && k < MAX_WAITERS - 1) begin
            task_in[k] = task_ff[k+1];
            prio_in[k] = prio_ff[k+1];
         end
      end
      total_in = total_ff;
      if (do_insert) begin
         total_in = total_ff + TOTAL_BITS'(1);
      end else if (do_remove) begin
         total_in = total_ff - TOTAL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff          <= csp_pkg::func_type'(req_func);
         id_ff            <= req_task_id;
         req_prio_ff      <= PRIORITY_BITS'(req_task_priority);
         ticks_zero_ff    <= req_timeout_ticks == '0;
         ticks_forever_ff <= req_timeout_ticks == csp_pkg::TIMEOUT_FOREVER;
      end
      if (cmd.exec) begin
         for (int k = 0; k < MAX_WAITERS; k++) begin
            task_ff[k] <= task_in[k];
            prio_ff[k] <= prio_in[k];
         end
         status_ff <= status_in;
         woken_ff  <= woken_in;
         timer_ff  <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ceiling_ff   <= csp_pkg::CEILING_RESET;
         count_ff     <= csp_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            total_ff <= total_in;
         end
         if (csr_valid && csr_index == csp_pkg::CSR_CEILING) begin
            ceiling_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_woken_task  = woken_ff;
   assign rsp_start_timer = timer_ff;
   assign rsp_count_now   = count_ff;

endmodule

`default_nettype wire

FILE: src/counting_semaphore_priority_wait_queue.sv
// Counting semaphore with a priority-sorted wait list of MAX_WAITERS cells.
// Request channel: an item (req_func, req_task_id, req_task_priority,
// req_timeout_ticks) is taken at a rising edge where start is high and busy
// is low. func 0 waits, 1 signals, 2 reports an expired timeout.
// Result channel: rsp_valid is high for one cycle with rsp_status,
// rsp_woken_task, rsp_start_timer and rsp_count_now; there is no back
// pressure, the receiver must take the item in that cycle.
// Timing: the item is latched at the accepting edge, the wait list and the
// count update in the following cycle, and the result shows in the cycle
// after that. busy is high for one cycle per item, during which the cell
// array inserts or removes one entry with all cells shifting in parallel;
// no item is taken while busy, but one can be taken as the result shows.
// Configuration: csr_index 0 writes the count ceiling, 1 writes the reload
// value and reloads the count; other indexes are dropped. csr_ready is
// always high; write only while no item is in flight.
// Reset (synchronous): the count goes to 0, the ceiling to 1, the wait
// list empties and no result is pending.
`default_nettype none

module counting_semaphore_priority_wait_queue #(
   parameter int MAX_WAITERS   = 16,
   parameter int NUM_TASKS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [1:0]                         req_func,
   input  wire  [csp_pkg::TASK_BITS-1:0]      req_task_id,
   input  wire  [csp_pkg::PORT_PRIO_BITS-1:0] req_task_priority,
   input  wire  [csp_pkg::TICKS_BITS-1:0]     req_timeout_ticks,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [csp_pkg::TASK_BITS-1:0]      rsp_woken_task,
   output logic                               rsp_start_timer,
   output logic [csp_pkg::COUNT_BITS-1:0]     rsp_count_now,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [csp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [csp_pkg::COUNT_BITS-1:0]     csr_wdata
);

   csp_pkg::ctrl_cmd_type cmd;

   assign csr_ready = 1'b1;

   csp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   csp_datapath #(
      .MAX_WAITERS   (MAX_WAITERS),
      .NUM_TASKS     (NUM_TASKS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_timeout_ticks (req_timeout_ticks),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_woken_task    (rsp_woken_task),
      .rsp_start_timer   (rsp_start_timer),
      .rsp_count_now     (rsp_count_now)
   );

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;

   localparam int MAX_WAITERS = 16;
   localparam int NUM_TASKS   = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int ITEMS_PER_SEGMENT = 50;

   localparam int TASK_W  = csp_pkg::TASK_BITS;
   localparam int PRIO_W  = csp_pkg::PORT_PRIO_BITS;
   localparam int COUNT_W = csp_pkg::COUNT_BITS;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [csp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [csp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [1:0]                         func;
      logic [csp_pkg::TASK_BITS-1:0]      task_id;
      logic [csp_pkg::PORT_PRIO_BITS-1:0] prio;
      logic [csp_pkg::TICKS_BITS-1:0]     ticks;
   } sem_request_type;

   typedef struct packed {
      logic [2:0]                     status;
      logic [csp_pkg::TASK_BITS-1:0]  woken;
      logic                           timer;
      logic [csp_pkg::COUNT_BITS-1:0] count;
   } sem_reply_type;

   typedef enum logic [1:0] {
      OP_ITEM,
      OP_CSR,
      OP_DRAIN
   } op_kind_type;

   typedef struct {
      op_kind_type                        kind;
      sem_request_type                    req;
      logic [csp_pkg::CSR_INDEX_BITS-1:0] csr_idx;
      logic [csp_pkg::COUNT_BITS-1:0]     csr_val;
      int unsigned                        idle_pct;
   } pending_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]                         req_func = '0;
   logic [csp_pkg::TASK_BITS-1:0]      req_task_id = '0;
   logic [csp_pkg::PORT_PRIO_BITS-1:0] req_task_priority = '0;
   logic [csp_pkg::TICKS_BITS-1:0]     req_timeout_ticks = '0;
   logic                               rsp_valid;
   logic [2:0]                         rsp_status;
   logic [csp_pkg::TASK_BITS-1:0]      rsp_woken_task;
   logic                               rsp_start_timer;
   logic [csp_pkg::COUNT_BITS-1:0]     rsp_count_now;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [csp_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [csp_pkg::COUNT_BITS-1:0]     csr_wdata = '0;

   // semaphore image kept by the testbench
   logic [csp_pkg::COUNT_BITS-1:0]     sem_count;
   logic [csp_pkg::COUNT_BITS-1:0]     sem_ceiling;
   logic [csp_pkg::TASK_BITS-1:0]      waiter_ids[MAX_WAITERS];
   logic [csp_pkg::PORT_PRIO_BITS-1:0] waiter_prios[MAX_WAITERS];
   int                                 waiter_cnt;

   pending_op_type  pending_ops[$];
   sem_reply_type   sem_replies[$];
   sem_request_type on_port;
   int              fault_count = 0;
   int              stall_cycles = 0;

   always #1 clock = ~clock;

   counting_semaphore_priority_wait_queue u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_timeout_ticks (req_timeout_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_woken_task    (rsp_woken_task),
      .rsp_start_timer   (rsp_start_timer),
      .rsp_count_now     (rsp_count_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic void drop_waiter(int pos);
      int k;
      for (k = pos; k + 1 < waiter_cnt; k++) begin
         waiter_ids[k]   = waiter_ids[k + 1];
         waiter_prios[k] = waiter_prios[k + 1];
      end
      waiter_cnt--;
   endfunction

   function automatic sem_reply_type semaphore_step(sem_request_type r);
      sem_reply_type o;
      int pos;
      int k;
      o = '0;
      case (r.func)
         csp_pkg::FUNC_WAIT: begin
            if (sem_count > 0) begin
               sem_count--;
               o.status = csp_pkg::STATUS_ACQUIRED;
            end else if (r.ticks == '0 || r.task_id >= NUM_TASKS) begin
               o.status = csp_pkg::STATUS_REFUSED;
            end else if (waiter_cnt >= MAX_WAITERS) begin
               o.status = csp_pkg::STATUS_FULL;
            end else begin
               // behind every waiter of equal or higher priority
               pos = 0;
               while (pos < waiter_cnt && waiter_prios[pos] >= r.prio)
                  pos++;
               for (k = waiter_cnt; k > pos; k--) begin
                  waiter_ids[k]   = waiter_ids[k - 1];
                  waiter_prios[k] = waiter_prios[k - 1];
               end
               waiter_ids[pos]   = r.task_id;
               waiter_prios[pos] = r.prio;
               waiter_cnt++;
               o.timer  = (r.ticks != csp_pkg::TIMEOUT_FOREVER);
               o.status = csp_pkg::STATUS_QUEUED;
            end
         end
         csp_pkg::FUNC_SIGNAL: begin
            if (waiter_cnt > 0) begin
               o.woken = waiter_ids[0];
               drop_waiter(0);
               o.status = csp_pkg::STATUS_WOKE;
            end else begin
               if (sem_count < sem_ceiling)
                  sem_count++;
               o.status = csp_pkg::STATUS_COUNTED;
            end
         end
         csp_pkg::FUNC_TIMEOUT: begin
            o.status = csp_pkg::STATUS_IGNORED;
            for (k = 0; k < waiter_cnt; k++) begin
               if (waiter_ids[k] == r.task_id) begin
                  drop_waiter(k);
                  o.status = csp_pkg::STATUS_REMOVED;
                  break;
               end
            end
         end
         default: begin
            o.status = csp_pkg::STATUS_IGNORED;
         end
      endcase
      o.count = sem_count;
      return o;
   endfunction

   function automatic sem_request_type make_req(logic [1:0] func, int id, int prio,
                                                logic [csp_pkg::TICKS_BITS-1:0] ticks);
      sem_request_type r;
      r.func    = func;
      r.task_id = TASK_W'(id);
      r.prio    = PRIO_W'(prio);
      r.ticks   = ticks;
      return r;
   endfunction

   function automatic sem_request_type random_request();
      sem_request_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         r.func = csp_pkg::FUNC_WAIT;
      else if (pick < 75)
         r.func = csp_pkg::FUNC_SIGNAL;
      else if (pick < 95)
         r.func = csp_pkg::FUNC_TIMEOUT;
      else
         r.func = FUNC_UNUSED;
      // a small id pool makes timeouts hit queued tasks
      r.task_id = TASK_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 31));
      // a narrow priority range makes ties common
      r.prio = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                             : $urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick == 0)
         r.ticks = '0;
      else if (pick < 3)
         r.ticks = csp_pkg::TIMEOUT_FOREVER;
      else if (pick == 3)
         r.ticks = 32'd1;
      else
         r.ticks = $urandom();
      return r;
   endfunction

   function automatic void queue_item(sem_request_type r, int unsigned pct);
      pending_op_type op;
      op.kind     = OP_ITEM;
      op.req      = r;
      op.csr_idx  = '0;
      op.csr_val  = '0;
      op.idle_pct = pct;
      pending_ops.push_back(op);
   endfunction

   function automatic void queue_csr(logic [csp_pkg::CSR_INDEX_BITS-1:0] idx,
                                     logic [csp_pkg::COUNT_BITS-1:0] val);
      pending_op_type op;
      op.kind     = OP_CSR;
      op.req      = '0;
      op.csr_idx  = idx;
      op.csr_val  = val;
      op.idle_pct = 0;
      pending_ops.push_back(op);
   endfunction

   function automatic void queue_drain();
      pending_op_type op;
      op.kind     = OP_DRAIN;
      op.req      = '0;
      op.csr_idx  = '0;
      op.csr_val  = '0;
      op.idle_pct = 0;
      pending_ops.push_back(op);
   endfunction

   // driver
   always @(posedge clock) begin
      pending_op_type op;
      logic nxt_start;
      logic nxt_csr;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         sem_ceiling = csp_pkg::CEILING_RESET;
         sem_count   = csp_pkg::COUNT_RESET;
         waiter_cnt  = 0;
      end else begin
         nxt_start = start;
         nxt_csr   = csr_valid;
         if (start && !busy) begin
            sem_replies.push_back(semaphore_step(on_port));
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == csp_pkg::CSR_CEILING) begin
               sem_ceiling = csr_wdata;
            end else if (csr_index == csp_pkg::CSR_RELOAD) begin
               sem_count = csr_wdata;
            end
            nxt_csr = 1'b0;
         end
         if (!nxt_start && !nxt_csr && pending_ops.size() > 0) begin
            op = pending_ops[0];
            case (op.kind)
               OP_ITEM: begin
                  if ($urandom_range(0, 99) >= op.idle_pct) begin
                     void'(pending_ops.pop_front());
                     on_port = op.req;
                     req_func          <= op.req.func;
                     req_task_id       <= op.req.task_id;
                     req_task_priority <= op.req.prio;
                     req_timeout_ticks <= op.req.ticks;
                     nxt_start = 1'b1;
                  end
               end
               OP_CSR: begin
                  // block is idle once every result is back
                  if (!start && !csr_valid && sem_replies.size() == 0) begin
                     void'(pending_ops.pop_front());
                     csr_index <= op.csr_idx;
                     csr_wdata <= op.csr_val;
                     nxt_csr = 1'b1;
                  end
               end
               default: begin
                  if (!start && sem_replies.size() == 0)
                     void'(pending_ops.pop_front());
               end
            endcase
         end
         start     <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   // monitor
   always @(posedge clock) begin
      sem_reply_type got;
      sem_reply_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_woken_task, rsp_start_timer, rsp_count_now};
         if (sem_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected item: status %0d woken %0d timer %0d count %0d",
                        got.status, got.woken, got.timer, got.count);
         end else begin
            want = sem_replies.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"mismatch: status %0d/%0d woken %0d/%0d timer %0d/%0d ",
                            "count %0d/%0d (expected/actual)"},
                           want.status, got.status, want.woken, got.woken,
                           want.timer, got.timer, want.count, got.count);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned phase_idle[3];
      int unsigned pct;
      int phase;
      int seg;
      int made;
      int n;
      int k;
      sem_request_type r;
      logic [csp_pkg::COUNT_BITS-1:0] pick_max;
      logic [csp_pkg::COUNT_BITS-1:0] pick_init;

      phase_idle = '{18, 81, 0};

      // directed part, registers at reset values: ceiling 1, count 0
      pct = phase_idle[0];
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd5), pct);
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd5), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 3, 9, 32'd5), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 3, 9, 32'd0), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 5, 10, 32'd1), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 31, 255, csp_pkg::TIMEOUT_FOREVER), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 0, 0, 32'hFFFF_FFFE), pct);
      // same task queued twice, then a tie with it
      queue_item(make_req(csp_pkg::FUNC_WAIT, 5, 10, 32'd100), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 7, 10, 32'd3), pct);
      queue_item(make_req(csp_pkg::FUNC_TIMEOUT, 5, 0, 32'd0), pct);
      queue_item(make_req(csp_pkg::FUNC_TIMEOUT, 20, 0, 32'd0), pct);
      queue_item(make_req(FUNC_UNUSED, 31, 255, csp_pkg::TIMEOUT_FOREVER), pct);
      repeat (5) queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd0), pct);
      // ceiling zero, then a count above the ceiling
      queue_csr(csp_pkg::CSR_CEILING, 16'd0);
      queue_csr(csp_pkg::CSR_RELOAD, 16'd0);
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd0), pct);
      queue_csr(csp_pkg::CSR_RELOAD, 16'd3);
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd0), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 1, 1, 32'd1), pct);
      queue_csr(CSR_SPARE_A, 16'hFFFF);
      queue_csr(CSR_SPARE_B, 16'h1234);
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd0), pct);
      queue_csr(csp_pkg::CSR_CEILING, 16'hFFFF);
      queue_csr(csp_pkg::CSR_RELOAD, 16'hFFFF);
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd0), pct);
      queue_item(make_req(csp_pkg::FUNC_WAIT, 2, 2, 32'd2), pct);
      queue_item(make_req(csp_pkg::FUNC_SIGNAL, 0, 0, 32'd0), pct);

      // random part: three idle phases, each with three register settings
      for (phase = 0; phase < 3; phase++) begin
         pct = phase_idle[phase];
         for (seg = 0; seg < 3; seg++) begin
            case ($urandom_range(0, 5))
               0: pick_max = 16'd0;
               1: pick_max = 16'd1;
               2: pick_max = 16'd2;
               3: pick_max = 16'd7;
               4: pick_max = 16'hFFFF;
               default: pick_max = COUNT_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
               0, 1: pick_init = 16'd0;
               2: pick_init = 16'd1;
               3: pick_init = 16'd2;
               4: pick_init = 16'hFFFF;
               default: pick_init = COUNT_W'($urandom_range(0, 65535));
            endcase
            queue_csr(csp_pkg::CSR_CEILING, pick_max);
            queue_csr(csp_pkg::CSR_RELOAD, pick_init);
            made = 0;
            while (made < ITEMS_PER_SEGMENT) begin
               k = $urandom_range(0, 9);
               if (k < 2) begin
                  // wait burst long enough to fill the list
                  n = $urandom_range(MAX_WAITERS + 1, MAX_WAITERS + 4);
                  repeat (n) begin
                     r = random_request();
                     r.func = csp_pkg::FUNC_WAIT;
                     if (r.ticks == '0)
                        r.ticks = csp_pkg::TIMEOUT_FOREVER;
                     queue_item(r, pct);
                  end
                  made += n;
               end else if (k == 2 && $urandom_range(0, 3) == 0) begin
                  queue_drain();
               end else begin
                  queue_item(random_request(), pct);
                  made++;
               end
            end
         end
      end
      queue_drain();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      fault_count += sem_replies.size();

      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
